>>> rtl/arp_pkg.sv
package arp_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = IDX_W + 1;

   localparam logic [1:0] ST_FREE    = 2'd0;
   localparam logic [1:0] ST_PENDING = 2'd1;
   localparam logic [1:0] ST_VALID   = 2'd2;

   localparam logic [2:0] CMD_UPDATE  = 3'd0;
   localparam logic [2:0] CMD_REMOVE  = 3'd1;
   localparam logic [2:0] CMD_CLEAR   = 3'd2;
   localparam logic [2:0] CMD_RESOLVE = 3'd3;
   localparam logic [2:0] CMD_RECEIVE = 3'd4;
   localparam logic [2:0] CMD_TICK    = 3'd5;
   localparam logic [2:0] CMD_AGE     = 3'd6;
   localparam logic [2:0] CMD_UNUSED  = 3'd7;

   localparam logic [1:0] REG_LOCAL_IP = 2'd0;
   localparam logic [1:0] REG_MASK     = 2'd1;
   localparam logic [1:0] REG_GATEWAY  = 2'd2;
   localparam logic [1:0] REG_TIMEOUT  = 2'd3;

   localparam logic [31:0] MASK_RESET    = 32'hFFFF_FF00;
   localparam logic [31:0] TIMEOUT_RESET = 32'd6000;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] addr_ip;
      logic [47:0] addr_mac;
      logic [31:0] tgt_ip;
      logic        is_request;
      logic        too_short;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [47:0] resolved_mac;
      logic        send_request;
      logic [31:0] request_ip;
      logic        send_reply;
   } rsp_type;

endpackage

>>> rtl/arp_req_if.sv
interface arp_req_if import arp_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> rtl/arp_rsp_if.sv
interface arp_rsp_if import arp_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> rtl/arp_cache_engine_core.sv
// ARP cache: 16 slots of IP, MAC, state and timestamp. One request word is
// taken at a time; req.ready is low until its response word has been taken.
// A sequencer walks the slots once per pass with a single shared compare
// unit, one slot per cycle: a lookup pass (IP match, first free slot, oldest
// timestamp all gathered together) then, except for clear and age, a write
// state. Update, remove, non-broadcast resolve and full-length receive run
// the scan, the write state and then offer the response; clear and age go
// from the scan straight to the response; tick, broadcast resolve, short
// receive and unknown commands offer the response directly. The response
// word is held until taken. Slot state has per-slot flops that reset
// clears at once, so there is no clearing pass. Configuration writes
// (csr_we/csr_addr/csr_wdata) are taken at any edge out of reset.
module arp_cache_engine_core import arp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   arp_req_if.sink     req,
   arp_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_WRITE = 2'd2;
   localparam logic [1:0] S_OUT = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [31:0] local_ip_ff, mask_ff, gateway_ff, timeout_ff;
   logic [31:0] tick_ff;
   req_type     cur_ff;
   logic [31:0] want_ff, want_in;
   rsp_type     rsp_ff, rsp_in;

   // slot store: status kept in flops (reset to free), payload in arrays
   logic [1:0]  status_ff [ENTRIES];
   logic [31:0] ip_mem [ENTRIES];
   logic [47:0] mac_mem [ENTRIES];
   logic [31:0] time_mem [ENTRIES];

   logic [CNT_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx;
   logic             found_ff, free_ff;
   logic [IDX_W-1:0] found_idx_ff, free_idx_ff, old_idx_ff;
   logic [31:0]      old_time_ff;

   assign idx = idx_ff[IDX_W-1:0];

   logic accept;
   assign accept = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.data = rsp_ff;

   // shared per-slot compare unit
   logic        occ, match, age_out;
   logic [31:0] age;
   assign occ = (status_ff[idx] != ST_FREE);
   assign match = occ && (ip_mem[idx] == want_ff);
   assign age = tick_ff - time_mem[idx];
   assign age_out = occ && (age > timeout_ff);

   logic bcast, offnet;
   assign bcast = (req.data.addr_ip == 32'hFFFF_FFFF);
   assign offnet = ((req.data.addr_ip & mask_ff) != (local_ip_ff & mask_ff));

   always_comb begin
      state_in = state_ff;
      want_in = want_ff;
      rsp_in = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_in = '0;
               want_in = req.data.addr_ip;
               if (req.data.cmd == CMD_RESOLVE && offnet) want_in = gateway_ff;
               case (req.data.cmd)
                  CMD_TICK: state_in = S_OUT;
                  CMD_RESOLVE: state_in = bcast ? S_OUT : S_SCAN;
                  CMD_RECEIVE: state_in = req.data.too_short ? S_OUT : S_SCAN;
                  CMD_UPDATE, CMD_REMOVE, CMD_CLEAR, CMD_AGE: state_in = S_SCAN;
                  default: state_in = S_OUT;
               endcase
               if (req.data.cmd == CMD_RESOLVE && bcast) begin
                  rsp_in.hit = 1'b1;
                  rsp_in.resolved_mac = '1;
               end
            end
         end
         S_SCAN: begin
            if (idx_ff == CNT_W'(ENTRIES - 1)) begin
               state_in = (cur_ff.cmd == CMD_CLEAR || cur_ff.cmd == CMD_AGE)
                          ? S_OUT : S_WRITE;
            end
         end
         S_WRITE: begin
            state_in = S_OUT;
            if (cur_ff.cmd == CMD_RESOLVE) begin
               if (found_ff && status_ff[found_idx_ff] == ST_VALID) begin
                  rsp_in.hit = 1'b1;
                  rsp_in.resolved_mac = mac_mem[found_idx_ff];
               end else begin
                  rsp_in.send_request = 1'b1;
                  rsp_in.request_ip = want_ff;
               end
            end
            if (cur_ff.cmd == CMD_RECEIVE && cur_ff.is_request &&
                cur_ff.tgt_ip == local_ip_ff)
               rsp_in.send_reply = 1'b1;
         end
         S_OUT: begin
            if (rsp.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // slot chosen for insertion: first free, else oldest
   logic [IDX_W-1:0] victim, wr_idx;
   assign victim = free_ff ? free_idx_ff : old_idx_ff;
   assign wr_idx = found_ff ? found_idx_ff : victim;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         local_ip_ff <= '0;
         mask_ff <= MASK_RESET;
         gateway_ff <= '0;
         timeout_ff <= TIMEOUT_RESET;
         tick_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) status_ff[i] <= ST_FREE;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_addr)
               REG_LOCAL_IP: local_ip_ff <= csr_wdata;
               REG_MASK: mask_ff <= csr_wdata;
               REG_GATEWAY: gateway_ff <= csr_wdata;
               REG_TIMEOUT: timeout_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (accept && req.data.cmd == CMD_TICK) tick_ff <= tick_ff + 32'd1;
         if (accept) idx_ff <= '0;
         if (state_ff == S_SCAN) begin
            idx_ff <= idx_ff + CNT_W'(1);
            if (cur_ff.cmd == CMD_CLEAR) status_ff[idx] <= ST_FREE;
            if (cur_ff.cmd == CMD_AGE && age_out) status_ff[idx] <= ST_FREE;
         end
         if (state_ff == S_WRITE) begin
            case (cur_ff.cmd)
               CMD_REMOVE: if (found_ff) status_ff[found_idx_ff] <= ST_FREE;
               CMD_UPDATE, CMD_RECEIVE: status_ff[wr_idx] <= ST_VALID;
               CMD_RESOLVE: if (!found_ff) status_ff[victim] <= ST_PENDING;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      want_ff <= want_in;
      rsp_ff <= rsp_in;
      if (accept) begin
         cur_ff <= req.data;
         found_ff <= 1'b0;
         free_ff <= 1'b0;
         found_idx_ff <= '0;
         free_idx_ff <= '0;
         old_idx_ff <= '0;
         old_time_ff <= '1;
      end
      if (state_ff == S_SCAN) begin
         if (match && !found_ff) begin
            found_ff <= 1'b1;
            found_idx_ff <= idx;
         end
         if (!occ && !free_ff) begin
            free_ff <= 1'b1;
            free_idx_ff <= idx;
         end
         // first slot always seeds the oldest; later ones only if strictly older
         if (idx_ff == '0 || time_mem[idx] < old_time_ff) begin
            old_idx_ff <= idx;
            old_time_ff <= time_mem[idx];
         end
      end
      if (state_ff == S_WRITE) begin
         case (cur_ff.cmd)
            CMD_UPDATE, CMD_RECEIVE: begin
               if (!found_ff) ip_mem[wr_idx] <= want_ff;
               mac_mem[wr_idx] <= cur_ff.addr_mac;
               time_mem[wr_idx] <= tick_ff;
            end
            CMD_RESOLVE: begin
               if (!found_ff) begin
                  ip_mem[victim] <= want_ff;
                  time_mem[victim] <= tick_ff;
               end
            end
            default: ;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !rsp.valid) else $error("ready while response pending");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (idx_ff < CNT_W'(ENTRIES)))
      else $error("scan index out of range");
   a_hit_excl: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !(rsp.data.hit && rsp.data.send_request))
      else $error("hit and request together");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid)
      else $error("response dropped");
`endif

endmodule
